/* src/sha1_pkg.sv */
// Shared types, constants and round functions for the SHA-1 stream hasher.
// Used by sha1_ctrl, sha1_dpath and sha1_stream_hasher; depends on nothing else.
package sha1_pkg;

  localparam int unsigned NUM_ROUNDS = 80;
  localparam int unsigned RND_W      = 7;
  localparam int unsigned BPOS_W     = 6;
  localparam int unsigned COUNT_W    = 61;

  localparam logic [BPOS_W-1:0] BPOS_LAST = 6'd63;
  localparam logic [BPOS_W-1:0] BPOS_PREL = 6'd55;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_GRP0 = 32'h5A827999;
  localparam logic [31:0] K_GRP1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_GRP2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_GRP3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Source of the byte shifted into the block window.
  typedef logic [1:0] bsel_t;
  localparam bsel_t BSEL_MSG  = 2'd0;
  localparam bsel_t BSEL_MARK = 2'd1;
  localparam bsel_t BSEL_ZERO = 2'd2;
  localparam bsel_t BSEL_LEN  = 2'd3;

  // Round groups of twenty rounds each.
  typedef logic [1:0] grp_t;
  localparam grp_t GRP_CH   = 2'd0;
  localparam grp_t GRP_PAR1 = 2'd1;
  localparam grp_t GRP_MAJ  = 2'd2;
  localparam grp_t GRP_PAR2 = 2'd3;

  typedef struct packed {
    logic  shift_byte;
    bsel_t byte_sel;
    logic  count_inc;
    logic  load_ae;
    logic  round;
    grp_t  grp;
    logic  update_h;
    logic  load_out;
    logic  reset_h;
  } cmd_t;

  typedef struct packed {
    logic [BPOS_W-1:0] bpos;
  } status_t;

  function automatic logic [31:0] round_k(input grp_t grp);
    logic [31:0] k;
    unique case (grp)
      GRP_CH:   k = K_GRP0;
      GRP_PAR1: k = K_GRP1;
      GRP_MAJ:  k = K_GRP2;
      default:  k = K_GRP3;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] round_f(input grp_t grp, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (grp)
      GRP_CH:  f = (b & c) | (~b & d);
      GRP_MAJ: f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

/* src/sha1_ctrl.sv */
// Controller for the SHA-1 stream hasher: sequences byte loading, padding,
// the 80 compression rounds and digest hand-off. Depends on sha1_pkg.
module sha1_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_byte_valid,
  input  logic              in_last,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  sha1_pkg::status_t status,
  output sha1_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_PAD   = 3'd3;
  localparam logic [2:0] S_LEN   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [sha1_pkg::RND_W-1:0] RND_LAST =
    sha1_pkg::RND_W'(sha1_pkg::NUM_ROUNDS - 1);

  logic [2:0]                 state_r, state_nxt;
  logic [sha1_pkg::RND_W-1:0] rnd_r, rnd_nxt;
  logic                       pad_r, pad_nxt;
  logic                       first_r, first_nxt;
  logic                       fin_r, fin_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       accept;
  logic                       block_full;

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign block_full = (status.bpos == sha1_pkg::BPOS_LAST);

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    pad_nxt       = pad_r;
    first_nxt     = first_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;

    if (rnd_r < 7'd20) begin
      cmd.grp = sha1_pkg::GRP_CH;
    end else if (rnd_r < 7'd40) begin
      cmd.grp = sha1_pkg::GRP_PAR1;
    end else if (rnd_r < 7'd60) begin
      cmd.grp = sha1_pkg::GRP_MAJ;
    end else begin
      cmd.grp = sha1_pkg::GRP_PAR2;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          pad_nxt   = in_last;
          first_nxt = in_last;
          if (in_byte_valid) begin
            cmd.shift_byte = 1'b1;
            cmd.byte_sel   = sha1_pkg::BSEL_MSG;
            cmd.count_inc  = 1'b1;
          end
          if (in_byte_valid && block_full) begin
            cmd.load_ae = 1'b1;
            rnd_nxt     = '0;
            state_nxt   = S_ROUND;
          end else if (in_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (rnd_r == RND_LAST) begin
          state_nxt = S_UPD;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      S_UPD: begin
        cmd.update_h = 1'b1;
        if (fin_r) begin
          state_nxt = S_DONE;
        end else if (pad_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PAD: begin
        cmd.shift_byte = 1'b1;
        cmd.byte_sel   = first_r ? sha1_pkg::BSEL_MARK : sha1_pkg::BSEL_ZERO;
        first_nxt      = 1'b0;
        if (block_full) begin
          // The marker did not leave room for the length: finish this block
          // and carry on padding in a fresh one.
          cmd.load_ae = 1'b1;
          rnd_nxt     = '0;
          state_nxt   = S_ROUND;
        end else if (status.bpos == sha1_pkg::BPOS_PREL) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        cmd.shift_byte = 1'b1;
        cmd.byte_sel   = sha1_pkg::BSEL_LEN;
        if (block_full) begin
          cmd.load_ae = 1'b1;
          rnd_nxt     = '0;
          fin_nxt     = 1'b1;
          state_nxt   = S_ROUND;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          cmd.reset_h   = 1'b1;
          out_valid_nxt = 1'b1;
          fin_nxt       = 1'b0;
          pad_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rnd_r       <= '0;
      pad_r       <= 1'b0;
      first_r     <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      pad_r       <= pad_nxt;
      first_r     <= first_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/sha1_dpath.sv */
// Datapath for the SHA-1 stream hasher: block window and message schedule,
// one-round compression unit, chaining words, byte count and digest register.
// Depends on sha1_pkg.
module sha1_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  sha1_pkg::cmd_t    cmd,
  input  logic [7:0]        msg_byte,
  output sha1_pkg::status_t status,
  output logic [31:0]       digest_word0,
  output logic [31:0]       digest_word1,
  output logic [31:0]       digest_word2,
  output logic [31:0]       digest_word3,
  output logic [31:0]       digest_word4
);

  logic [31:0]                  win_r [16];
  logic [31:0]                  h_r   [5];
  logic [31:0]                  dig_r [5];
  logic [31:0]                  a_r, b_r, c_r, d_r, e_r;
  logic [sha1_pkg::COUNT_W-1:0] count_r;
  logic [sha1_pkg::BPOS_W-1:0]  bpos_r;
  logic [63:0]                  len_bits;
  logic [5:0]                   len_base;
  logic [7:0]                   byte_in;
  logic [31:0]                  sched_x;
  logic [31:0]                  sched;
  logic [31:0]                  t_sum;

  // The length goes out most significant byte first at buffer places 56..63.
  assign len_bits = {count_r, 3'b000};
  assign len_base = {~bpos_r[2:0], 3'b000};

  always_comb begin
    unique case (cmd.byte_sel)
      sha1_pkg::BSEL_MSG:  byte_in = msg_byte;
      sha1_pkg::BSEL_MARK: byte_in = sha1_pkg::PAD_MARK;
      sha1_pkg::BSEL_ZERO: byte_in = 8'h00;
      default:             byte_in = len_bits[len_base +: 8];
    endcase
  end

  // Window word 0 is always W[t]; the word appended is W[t+16].
  assign sched_x = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign sched   = {sched_x[30:0], sched_x[31]};

  assign t_sum = {a_r[26:0], a_r[31:27]} + sha1_pkg::round_f(cmd.grp, b_r, c_r, d_r)
               + e_r + win_r[0] + sha1_pkg::round_k(cmd.grp);

  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_r[15] <= {win_r[15][23:0], byte_in};
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= sched;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ae) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.round) begin
      a_r <= t_sum;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reset_h) begin
      for (int i = 0; i < 5; i++) begin
        h_r[i] <= sha1_pkg::H_INIT[i];
      end
      count_r <= '0;
    end else begin
      if (cmd.update_h) begin
        h_r[0] <= h_r[0] + a_r;
        h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r;
        h_r[4] <= h_r[4] + e_r;
      end
      if (cmd.count_inc) begin
        count_r <= count_r + 61'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpos_r <= '0;
    end else if (cmd.shift_byte) begin
      bpos_r <= bpos_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int i = 0; i < 5; i++) begin
        dig_r[i] <= h_r[i];
      end
    end
  end

  assign status.bpos  = bpos_r;
  assign digest_word0 = dig_r[0];
  assign digest_word1 = dig_r[1];
  assign digest_word2 = dig_r[2];
  assign digest_word3 = dig_r[3];
  assign digest_word4 = dig_r[4];

endmodule

/* src/sha1_stream_hasher.sv */
// Top level of the SHA-1 stream hasher: joins controller and datapath.
// Depends on sha1_pkg, sha1_ctrl and sha1_dpath.
//
//   word     direction  handshake             payload
//   input    in         in_valid / in_stall   in_msg_byte, in_byte_valid, in_last
//   digest   out        out_valid / out_stall out_digest_word0 .. out_digest_word4
//
// One message byte is taken per cycle while the hasher is idle; the 64th byte
// of a block starts the compression: 80 rounds and then a chaining update.
// A last word adds the padding, byte by byte up to the block end, and one or
// two compressions; the digest then goes via S_DONE to the output register.
// Reset (rst_n low at a clock edge) restores the initial chaining words and a
// zero byte count. A waiting digest does not stop new bytes; only the next
// digest waits for the output register to free up.
module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_byte_valid,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word0,
  output logic [31:0] out_digest_word1,
  output logic [31:0] out_digest_word2,
  output logic [31:0] out_digest_word3,
  output logic [31:0] out_digest_word4
);

  sha1_pkg::cmd_t    cmd;
  sha1_pkg::status_t status;

  sha1_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_byte_valid (in_byte_valid),
    .in_last       (in_last),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .cmd           (cmd)
  );

  sha1_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .msg_byte     (in_msg_byte),
    .status       (status),
    .digest_word0 (out_digest_word0),
    .digest_word1 (out_digest_word1),
    .digest_word2 (out_digest_word2),
    .digest_word3 (out_digest_word3),
    .digest_word4 (out_digest_word4)
  );

  // Compression starts only as the final byte of a block goes in.
  a_start_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_ae |-> (cmd.shift_byte && status.bpos == sha1_pkg::BPOS_LAST))
    else $error("compression started on a partial block");

  // No input word is taken while rounds are running.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round |-> in_stall)
    else $error("input accepted during compression");

  // A digest that is still waiting is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("waiting digest overwritten");

  // Only message bytes advance the byte count.
  a_count_msg: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.count_inc |-> (cmd.shift_byte && cmd.byte_sel == sha1_pkg::BSEL_MSG))
    else $error("byte count advanced by a padding byte");

endmodule

/* sim/sha1_digest_checker.sv */
// Checker for the SHA-1 stream hasher: watches the input and digest channels, keeps
// its own SHA-1 state and compares every digest word with the expected one.
// Stands alone; the testbench top instantiates it beside the hasher.
module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_byte_valid,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word0,
  input  logic [31:0] out_digest_word1,
  input  logic [31:0] out_digest_word2,
  input  logic [31:0] out_digest_word3,
  input  logic [31:0] out_digest_word4,
  output int          mismatches,
  output int          digests_pending
);

  typedef logic [4:0][31:0] digest_t;

  localparam digest_t CHAIN_START = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  digest_t     chain;
  logic [7:0]  blk [64];
  logic [60:0] byte_count;
  digest_t     digest_q [$];
  digest_t     got;
  digest_t     want;
  logic [63:0] bit_len;
  int          pos;
  int          fails;

  // One 80-round compression of blk into the chaining words.
  function automatic void absorb_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = {a[26:0], a[31:27]} + f + e + w[i] + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
    chain[4] = chain[4] + e;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      chain = CHAIN_START;
      byte_count = '0;
      digest_q.delete();
    end else begin
      // The input side is handled first so that a digest could never beat its word.
      if (in_valid && !in_stall) begin
        if (in_byte_valid) begin
          pos = int'(byte_count[5:0]);
          blk[pos] = in_msg_byte;
          byte_count = byte_count + 61'd1;
          if (pos == 63)
            absorb_block();
        end
        if (in_last) begin
          pos = int'(byte_count[5:0]);
          blk[pos] = 8'h80;
          pos++;
          // With no room left for the length, the padding spills into an extra block.
          if (pos > 56) begin
            for (int i = pos; i < 64; i++)
              blk[i] = 8'h00;
            absorb_block();
            for (int i = 0; i < 56; i++)
              blk[i] = 8'h00;
          end else begin
            for (int i = pos; i < 56; i++)
              blk[i] = 8'h00;
          end
          bit_len = {byte_count, 3'b000};
          for (int i = 0; i < 8; i++)
            blk[56+i] = bit_len[63-8*i -: 8];
          absorb_block();
          digest_q.push_back(chain);
          chain = CHAIN_START;
          byte_count = '0;
        end
      end

      if (out_valid && !out_stall) begin
        got = {out_digest_word4, out_digest_word3, out_digest_word2,
               out_digest_word1, out_digest_word0};
        if (digest_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected digest: expected none, got %h", $time, got);
        end else begin
          want = digest_q.pop_front();
          for (int i = 0; i < 5; i++) begin
            if (got[i] !== want[i]) begin
              fails++;
              $display("%0t: digest_word%0d: expected %h, got %h",
                       $time, i, want[i], got[i]);
            end
          end
        end
      end
    end
    mismatches <= fails;
    digests_pending <= digest_q.size();
  end

endmodule

/* sim/sha1_stream_hasher_test.sv */
// Testbench top for the SHA-1 stream hasher: drives messages word by word with
// random gaps and digest stalls, and gives the verdict from sha1_digest_checker.
// Depends on sha1_stream_hasher and sha1_digest_checker.
module sha1_stream_hasher_test;

  localparam int PAD_EDGE_LENS [13] = '{0, 1, 54, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_msg_byte = 8'h00;
  logic        in_byte_valid = 1'b0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word0;
  logic [31:0] out_digest_word1;
  logic [31:0] out_digest_word2;
  logic [31:0] out_digest_word3;
  logic [31:0] out_digest_word4;
  logic        calm = 1'b0;
  int          mismatches;
  int          digests_pending;
  int          words_sent = 0;
  int          messages_done = 0;

  sha1_stream_hasher i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_msg_byte      (in_msg_byte),
    .in_byte_valid    (in_byte_valid),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digest_word0 (out_digest_word0),
    .out_digest_word1 (out_digest_word1),
    .out_digest_word2 (out_digest_word2),
    .out_digest_word3 (out_digest_word3),
    .out_digest_word4 (out_digest_word4)
  );

  sha1_digest_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_msg_byte      (in_msg_byte),
    .in_byte_valid    (in_byte_valid),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digest_word0 (out_digest_word0),
    .out_digest_word1 (out_digest_word1),
    .out_digest_word2 (out_digest_word2),
    .out_digest_word3 (out_digest_word3),
    .out_digest_word4 (out_digest_word4),
    .mismatches       (mismatches),
    .digests_pending  (digests_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk)
    out_stall <= !calm && ($urandom_range(99) < 11);

  // Puts one word on the input channel and returns at the edge that accepts it.
  task automatic send_word(input logic [7:0] b, input logic bv, input logic l);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_msg_byte   <= b;
    in_byte_valid <= bv;
    in_last       <= l;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    if (bv || l)
      words_sent++;
  endtask

  // A message of len random bytes, ended either on its final byte or by a
  // separate last word, with an occasional empty word mixed in.
  task automatic send_message(input int len, input logic last_on_byte);
    for (int j = 0; j < len; j++) begin
      if ($urandom_range(99) < 5)
        send_word(8'($urandom_range(255)), 1'b0, 1'b0);
      send_word(8'($urandom_range(255)), 1'b1, last_on_byte && (j == len - 1));
    end
    if (!last_on_byte || len == 0)
      send_word(8'($urandom_range(255)), 1'b0, 1'b1);
    messages_done++;
  endtask

  initial begin
    int len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message, then single-byte messages at both byte extremes.
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hFF, 1'b1, 1'b1);
    // "abc" with an empty word inside and a separate last word.
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h5A, 1'b0, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b0);
    send_word(8'hA5, 1'b0, 1'b1);
    // "abc" again, ended on its last byte.
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    messages_done = 5;

    while (words_sent < 1500 || messages_done < 22) begin
      calm <= (messages_done >= 14 && messages_done < 22);
      if ($urandom_range(1))
        len = PAD_EDGE_LENS[$urandom_range(12)];
      else
        len = $urandom_range(70);
      send_message(len, 1'($urandom_range(1)));
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (digests_pending != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);

    if (mismatches == 0 && digests_pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
